/* hw/rtl/clsx_pkg.sv */
// Shared types, constants and character-class functions for the source lexer.
// No dependencies; used by every module of the lexer.
package clsx_pkg;

	localparam int LINE_LEN   = 4096;
	localparam int LINE_COUNT = 65536;

	localparam int LINE_W = 16;
	localparam int COL_W  = 12;
	localparam int LEN_W  = 13;
	localparam int CH_W   = 8;
	localparam int KIND_W = 2;
	localparam int CMD_W  = 2;

	localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(LINE_LEN - 1);
	localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINE_COUNT - 1);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(LINE_LEN);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CH_W-1:0] CH_US    = 8'h5F;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CH_W-1:0] CH_E_LO  = 8'h65;
	localparam logic [CH_W-1:0] CH_E_UP  = 8'h45;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

	typedef enum logic [CMD_W-1:0] {
		CMD_CHAR = 2'd0,
		CMD_EOL  = 2'd1,
		CMD_EOI  = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		K_IDENT  = 2'd0,
		K_NUMBER = 2'd1,
		K_SYMBOL = 2'd2,
		K_END    = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_SLASH  = 4'd1,
		M_LCMT   = 4'd2,
		M_BLOCK  = 4'd3,
		M_STAR   = 4'd4,
		M_IDENT  = 4'd5,
		M_ZERO   = 4'd6,
		M_DEC    = 4'd7,
		M_FRAC   = 4'd8,
		M_EXP    = 4'd9,
		M_ESIGN  = 4'd10,
		M_EDIG   = 4'd11,
		M_HEX    = 4'd12,
		M_SUFFIX = 4'd13,
		M_STOP   = 4'd15
	} mode_t;

	typedef struct packed {
		kind_t             kind;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
		logic [LEN_W-1:0]  len;
		logic [CH_W-1:0]   sym;
		logic              unc;
		logic              last;
	} res_t;

	// up to two results per transaction, first slot always used first
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	function automatic logic is_alpha(logic [CH_W-1:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(logic [CH_W-1:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(logic [CH_W-1:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_space(logic [CH_W-1:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_exp(logic [CH_W-1:0] c);
		return c == CH_E_LO || c == CH_E_UP;
	endfunction

	// next mode of an open token on byte c; M_STOP ends the token
	function automatic mode_t next_tok(mode_t m, logic [CH_W-1:0] c);
		mode_t r;
		r = is_alpha(c) ? M_SUFFIX : M_STOP;
		case (m)
			M_IDENT: begin
				if (is_alpha(c) || is_digit(c) || c == CH_US) r = M_IDENT;
				else r = M_STOP;
			end
			M_ZERO, M_DEC: begin
				if (m == M_ZERO && (c == CH_X_LO || c == CH_X_UP)) r = M_HEX;
				else if (is_digit(c)) r = M_DEC;
				else if (c == CH_DOT) r = M_FRAC;
				else if (is_exp(c)) r = M_EXP;
			end
			M_FRAC: begin
				if (is_digit(c)) r = M_FRAC;
				else if (is_exp(c)) r = M_EXP;
			end
			M_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS) r = M_ESIGN;
				else if (is_digit(c)) r = M_EDIG;
			end
			M_ESIGN, M_EDIG: begin
				if (is_digit(c)) r = M_EDIG;
			end
			M_HEX: begin
				if (is_hex(c)) r = M_HEX;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/clsx_core.sv */
// Lexer state registers and the single-step transition logic.
// Depends on clsx_pkg; produces up to two results per step for clsx_outq.
module clsx_core import clsx_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [CH_W-1:0]   ch,
	output push_t             push
);

	mode_t             mode_q, mode_d;
	logic [LINE_W-1:0] line_q, line_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [COL_W-1:0]  tstart_q, tstart_d;
	logic [LEN_W-1:0]  tlen_q, tlen_d;

	logic  in_tok, pending, blk, a, b, idle;
	mode_t nm;
	res_t  fl_res, b_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			line_q   <= '0;
			col_q    <= '0;
			tstart_q <= '0;
			tlen_q   <= '0;
		end else if (step) begin
			mode_q   <= mode_d;
			line_q   <= line_d;
			col_q    <= col_d;
			tstart_q <= tstart_d;
			tlen_q   <= tlen_d;
		end
	end

	assign in_tok  = mode_q >= M_IDENT && mode_q <= M_SUFFIX;
	assign pending = in_tok || mode_q == M_SLASH;
	assign blk     = mode_q == M_BLOCK || mode_q == M_STAR;
	assign nm      = next_tok(mode_q, ch);

	always_comb begin
		fl_res.kind = in_tok ? ((mode_q == M_IDENT) ? K_IDENT : K_NUMBER) : K_SYMBOL;
		fl_res.line = line_q;
		fl_res.col  = tstart_q;
		fl_res.len  = in_tok ? tlen_q : LEN_W'(1);
		fl_res.sym  = in_tok ? '0 : CH_SLASH;
		fl_res.unc  = 1'b0;
		fl_res.last = 1'b0;
	end

	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		col_d    = col_q;
		tstart_d = tstart_q;
		tlen_d   = tlen_q;
		a        = 1'b0;
		b        = 1'b0;
		idle     = 1'b0;
		b_res    = '{kind: K_SYMBOL, line: line_q, col: col_q, len: LEN_W'(1),
			sym: ch, unc: 1'b0, last: 1'b0};
		case (cmd_t'(cmd))
			CMD_EOL: begin
				a      = pending;
				mode_d = blk ? M_BLOCK : M_IDLE;
				if (line_q != LINE_MAX) line_d = line_q + LINE_W'(1);
				col_d  = '0;
			end
			CMD_EOI: begin
				a        = pending;
				b        = 1'b1;
				b_res    = '{kind: K_END, line: line_q, col: col_q, len: '0,
					sym: '0, unc: blk, last: 1'b0};
				mode_d   = M_IDLE;
				line_d   = '0;
				col_d    = '0;
				tstart_d = '0;
				tlen_d   = '0;
			end
			CMD_CHAR: begin
				case (mode_q)
					M_IDENT, M_ZERO, M_DEC, M_FRAC, M_EXP, M_ESIGN, M_EDIG, M_HEX,
					M_SUFFIX: begin
						if (nm == M_STOP) begin
							a      = 1'b1;
							mode_d = M_IDLE;
							idle   = 1'b1;
						end else begin
							mode_d = nm;
							if (tlen_q < LEN_MAX) tlen_d = tlen_q + LEN_W'(1);
						end
					end
					M_SLASH: begin
						if (ch == CH_SLASH) mode_d = M_LCMT;
						else if (ch == CH_STAR) mode_d = M_BLOCK;
						else begin
							a      = 1'b1;
							mode_d = M_IDLE;
							idle   = 1'b1;
						end
					end
					M_BLOCK: begin
						if (ch == CH_STAR) mode_d = M_STAR;
					end
					M_STAR: begin
						if (ch == CH_SLASH) mode_d = M_IDLE;
						else if (ch != CH_STAR) mode_d = M_BLOCK;
					end
					M_LCMT: begin
					end
					default: begin
						mode_d = M_IDLE;
						idle   = 1'b1;
					end
				endcase
				if (idle && !is_space(ch)) begin
					if (is_alpha(ch) || ch == CH_US || is_digit(ch) || ch == CH_SLASH) begin
						tstart_d = col_q;
						tlen_d   = LEN_W'(1);
						if (is_digit(ch)) mode_d = (ch == CH_ZERO) ? M_ZERO : M_DEC;
						else if (ch == CH_SLASH) mode_d = M_SLASH;
						else mode_d = M_IDENT;
					end else begin
						b = 1'b1;
					end
				end
				if (col_q != COL_MAX) col_d = col_q + COL_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push.v0 = a || b;
		push.v1 = a && b;
		push.r0 = a ? fl_res : b_res;
		push.r1 = b_res;
		push.r0.last = !(a && b);
		push.r1.last = 1'b1;
	end

endmodule

/* hw/rtl/clsx_outq.sv */
// Small result queue: takes up to two results per cycle, sends one per transaction.
// Depends on clsx_pkg.
module clsx_outq import clsx_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_en,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            pop, w0, w1;
	logic [Q_AW:0]   n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rd_q];
	assign room      = cnt_q <= (Q_AW+1)'(Q_DEPTH - 2);
	assign w0        = push_en && push.v0;
	assign w1        = push_en && push.v1;
	assign n_push    = (Q_AW+1)'(w0) + (Q_AW+1)'(w1);

	always_ff @(posedge clk) begin
		if (w0) mem_q[wr_q] <= push.r0;
		if (w1) mem_q[wr_q + Q_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[Q_AW-1:0];
			if (pop) rd_q <= rd_q + Q_AW'(1);
			cnt_q <= cnt_q + n_push - (Q_AW+1)'(pop);
		end
	end

endmodule

/* hw/rtl/c_style_source_lexer_unit.sv */
// C-style source lexer top: input register, lexer step logic and result queue.
// Path: an accepted input is registered, then its results are queued for the output.
// Throughput: one input transaction per cycle while the 4-entry result queue has room
// for two results; output delivers one result per cycle while m_axis_tready is high,
// so a run of two-result steps is limited by the output port.
// Reset: arst_n clears lexer state, input register and queue; no clearing pass.
module c_style_source_lexer_unit import clsx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // ch[7:0]
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // line[15:0], column[27:16], token_len[40:28],
	                                   // symbol_char[48:41], unclosed_comment[49], zero[55:50]
	output logic [1:0]  m_axis_tuser,  // token_kind[1:0]
	output logic        m_axis_tlast
);

	logic             valid_s1;
	logic [CMD_W-1:0] cmd_s1;
	logic [CH_W-1:0]  ch_s1;
	logic             room, advance;
	push_t            push;
	res_t             out_res;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1 <= s_axis_tuser;
			ch_s1  <= s_axis_tdata;
		end
	end

	clsx_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cmd    (cmd_s1),
		.ch     (ch_s1),
		.push   (push)
	);

	clsx_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (advance),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {6'b0, out_res.unc, out_res.sym, out_res.len, out_res.col, out_res.line};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule
